### sv/handshake_serial_byte_link_assert.svh
// Assertion macros for the serial byte link checker.
// Each macro expands to one labeled concurrent assertion with a disable iff guard on the active-low reset.
`ifndef HANDSHAKE_SERIAL_BYTE_LINK_ASSERT_SVH
`define HANDSHAKE_SERIAL_BYTE_LINK_ASSERT_SVH

// Same-cycle implication.
`define HSBL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HSBL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/hsbl_pkg.sv
// Shared types and constants for the serial byte link.
// No dependencies; used by the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package hsbl_pkg;

    // Stream payload widths, padded to whole bytes
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;
    localparam int BYTE_W      = 8;
    localparam int LEVEL_W     = 5;

    // Bit positions in the line level vector
    localparam int LVL_A    = 0;
    localparam int LVL_B    = 1;
    localparam int LVL_DATA = 2;
    localparam int LVL_ACK  = 3;

    // Role register codes
    localparam logic ROLE_SENDER   = 1'b0;
    localparam logic ROLE_RECEIVER = 1'b1;

    // Handshake phase
    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_WAIT_HI = 3'b010,
        PH_WAIT_LO = 3'b100
    } t_phase;

    // Input item
    typedef struct packed {
        logic [2:0]        pad;
        logic [BYTE_W-1:0] push_byte;
        logic              push_valid;
        logic              serial_in;
        logic              strobe_b_in;
        logic              strobe_a_in;
        logic              ack_in;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [4:0]         pad;
        logic               push_dropped;
        logic [LEVEL_W-1:0] tx_level;
        logic [BYTE_W-1:0]  rx_byte;
        logic               rx_valid;
        logic               ack_out;
        logic               serial_out;
        logic               strobe_b_out;
        logic               strobe_a_out;
    } t_out_item;

endpackage

`default_nettype wire

### sv/handshake_serial_byte_link.sv
// Each accepted input yields one result in the output register. Throughput: one item
// per cycle unless the output stalls; the head byte of the transmit queue is prefetched
// from the queue memory every cycle, with write forwarding, so no item waits on the read.
// Reset: synchronous, active low; clears role, handshake state, queue pointers and output
// valid, not output data; queue memory is not cleared and needs no clearing pass.
// Depends on hsbl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module handshake_serial_byte_link #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int BITS_PER_BYTE = 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Input items
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // ack_in, strobe_a_in, strobe_b_in, serial_in, push_valid, push_byte[7:0], zeros
    input  wire logic [hsbl_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // Result items
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // strobe_a_out, strobe_b_out, serial_out, ack_out, rx_valid, rx_byte[7:0],
    // tx_level[4:0], push_dropped, zeros
    output logic [hsbl_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // Role register write
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic                            i_cfg_data
);
    import hsbl_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = ((AW > CW) ? AW : CW) + 1;
    localparam logic [AW-1:0] HEAD_LAST  = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(QUEUE_DEPTH);
    localparam logic [SW-1:0] DEPTH_S    = SW'(QUEUE_DEPTH);
    localparam logic [3:0]    BIT_LIMIT  = 4'(BITS_PER_BYTE);
    localparam logic [7:0]    BYTE_MASK  = 8'((16'd1 << BITS_PER_BYTE) - 16'd1);

    // Queue memory and its registered read port
    logic [BYTE_W-1:0] r_mem [QUEUE_DEPTH];
    logic [BYTE_W-1:0] r_rd;

    logic              r_role;
    t_phase            r_phase, n_phase;
    logic [3:0]        r_bc, n_bc;
    logic [7:0]        r_sr, n_sr;
    logic              r_use_a, n_use_a;
    logic [3:0]        r_lvl, n_lvl;
    logic [AW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_count, n_count;
    logic              r_out_valid;
    t_out_item         r_out, n_out;

    t_in_item          in_item;
    logic              accept;
    logic              strobe;
    logic [7:0]        sr_src;
    logic [3:0]        bc_inc;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [SW-1:0]     wr_sum;
    logic [CW-1:0]     link_count;
    logic [AW-1:0]     link_head;

    assign in_item       = t_in_item'(s_axis_tdata);
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    always_comb begin
        n_phase    = r_phase;
        n_bc       = r_bc;
        n_sr       = r_sr;
        n_use_a    = r_use_a;
        n_lvl      = r_lvl;
        link_head  = r_head;
        link_count = r_count;
        n_out      = '0;
        strobe     = r_use_a ? in_item.strobe_a_in : in_item.strobe_b_in;
        sr_src     = (r_bc == 4'd0) ? r_rd : r_sr;
        bc_inc     = r_bc + 4'd1;

        if (r_role == ROLE_SENDER) begin
            unique case (r_phase)
                PH_WAIT_HI: begin
                    if (in_item.ack_in) begin
                        n_lvl[LVL_A] = 1'b0;
                        n_lvl[LVL_B] = 1'b0;
                        n_phase      = PH_WAIT_LO;
                    end
                end
                PH_WAIT_LO: begin
                    if (!in_item.ack_in) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    if (r_count != '0) begin
                        n_lvl[LVL_DATA] = sr_src[BITS_PER_BYTE-1];
                        n_sr            = {sr_src[6:0], 1'b0};
                        if (r_use_a) begin
                            n_lvl[LVL_A] = 1'b1;
                        end else begin
                            n_lvl[LVL_B] = 1'b1;
                        end
                        n_phase = PH_WAIT_HI;
                        n_use_a = !r_use_a;
                        n_bc    = bc_inc;
                        // Retire the byte on its last strobe
                        if (bc_inc >= BIT_LIMIT) begin
                            link_head  = (r_head == HEAD_LAST) ? '0 : r_head + AW'(1);
                            link_count = r_count - CW'(1);
                            n_bc       = 4'd0;
                        end
                    end
                end
            endcase
        end else begin
            if (r_phase == PH_IDLE) begin
                if (strobe) begin
                    n_sr           = {r_sr[6:0], in_item.serial_in};
                    n_lvl[LVL_ACK] = 1'b1;
                    n_phase        = PH_WAIT_HI;
                    n_bc           = bc_inc;
                end
            end else if (!strobe) begin
                n_phase        = PH_IDLE;
                n_lvl[LVL_ACK] = 1'b0;
                n_use_a        = !r_use_a;
            end
            if (n_bc >= BIT_LIMIT) begin
                n_out.rx_valid = 1'b1;
                n_out.rx_byte  = n_sr & BYTE_MASK;
                n_sr           = 8'd0;
                n_bc           = 4'd0;
            end
        end

        // Append the push after the link logic
        n_head  = link_head;
        n_count = link_count;
        wr_sum  = SW'(link_head) + SW'(link_count);
        wr_addr = AW'((wr_sum >= DEPTH_S) ? wr_sum - DEPTH_S : wr_sum);
        wr_en   = 1'b0;
        if (in_item.push_valid) begin
            if (link_count < COUNT_FULL) begin
                wr_en   = accept;
                n_count = link_count + CW'(1);
            end else begin
                n_out.push_dropped = 1'b1;
            end
        end

        if (r_role == ROLE_SENDER) begin
            n_out.strobe_a_out = n_lvl[LVL_A];
            n_out.strobe_b_out = n_lvl[LVL_B];
            n_out.serial_out   = n_lvl[LVL_DATA];
        end else begin
            n_out.ack_out = n_lvl[LVL_ACK];
        end
        n_out.tx_level = LEVEL_W'({{LEVEL_W{1'b0}}, n_count});

        rd_addr = accept ? n_head : r_head;
    end

    // Queue memory: one write, one registered read; forward a same-address write
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= in_item.push_byte;
        end
        if (wr_en && (wr_addr == rd_addr)) begin
            r_rd <= in_item.push_byte;
        end else begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_role      <= ROLE_SENDER;
            r_phase     <= PH_IDLE;
            r_bc        <= 4'd0;
            r_sr        <= 8'd0;
            r_use_a     <= 1'b1;
            r_lvl       <= 4'd0;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_role <= i_cfg_data;
            end
            if (accept) begin
                r_phase <= n_phase;
                r_bc    <= n_bc;
                r_sr    <= n_sr;
                r_use_a <= n_use_a;
                r_lvl   <= n_lvl;
                r_head  <= n_head;
                r_count <= n_count;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result until its transfer
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

### sv/hsbl_checker.sv
// Port-level checker for the serial byte link, bound to the top level.
// Depends on hsbl_pkg and handshake_serial_byte_link_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "handshake_serial_byte_link_assert.svh"

module hsbl_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_s_tready,
    input wire logic                             i_m_tvalid,
    input wire logic                             i_m_tready,
    input wire logic [hsbl_pkg::OUT_TDATA_W-1:0] i_m_tdata
);
    import hsbl_pkg::*;

    t_out_item res;
    assign res = t_out_item'(i_m_tdata);

    `HSBL_ASSERT_NEXT(a_hold_result, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata), "result changed while stalled")
    `HSBL_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !i_m_tvalid, i_s_tready, "input stalled with empty output register")
    `HSBL_ASSERT_NOW(a_role_lines, i_clk, i_rst_n, i_m_tvalid && res.ack_out, !res.strobe_a_out && !res.strobe_b_out && !res.serial_out, "sender and receiver lines driven together")
    `HSBL_ASSERT_NOW(a_rx_byte_zero, i_clk, i_rst_n, i_m_tvalid && !res.rx_valid, res.rx_byte == '0, "received byte nonzero without a completed byte")

endmodule

bind handshake_serial_byte_link hsbl_checker u_hsbl_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);

`default_nettype wire
